@@ hw/rtl/vobc_pkg.sv @@
// Shared types and constants for the variable-offset block chopper.
// Used by vobc_ctrl, vobc_dp and the top level; depends on nothing.
package vobc_pkg;

    localparam int OFS_W      = 16;  // offset field width
    localparam int OUT_W      = 16;  // out_sample field width
    localparam int IDX_W      = 17;  // source index: slot - pad + skip, skip up to 2^15
    localparam int PAD_W      = 15;  // pad is a non-negative offset
    localparam int RC_REG_W   = 9;   // read_count register width
    localparam int WC_REG_W   = 7;   // write_count register width
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [RC_REG_W-1:0] RC_RESET = 9'd128;
    localparam logic [WC_REG_W-1:0] WC_RESET = 7'd64;

    localparam logic [CFG_IDX_W-1:0] REG_READ_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_COUNT = 2'd1;

    // Controller to datapath commands.
    typedef struct packed {
        logic accept_en;  // input channel is open
        logic rd_issue;   // read the store for the current slot
        logic load;       // load the output register with the current slot
    } vobc_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic block_done; // accepted transaction completes the block
        logic out_busy;   // output register stays full this cycle
        logic slot_last;  // current slot is the final one of the block
    } vobc_stat_t;

endpackage

@@ hw/rtl/vobc_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module vobc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hw/rtl/vobc_ctrl.sv @@
// Sequencer for the block chopper: fill, then read and load one result at a time.
// Depends on vobc_pkg for the command and status structs.
module vobc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  vobc_pkg::vobc_stat_t stat,
    output vobc_pkg::vobc_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_FILL,
        ST_READ,
        ST_LOAD
    } state_t;

    state_t state_reg;
    logic   ready_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_FILL;
            ready_reg <= 1'b1;
        end else begin
            unique case (state_reg)
                ST_FILL: begin
                    if (stat.block_done) begin
                        state_reg <= ST_READ;
                        ready_reg <= 1'b0;
                    end
                end
                ST_READ: begin
                    if (!stat.out_busy) begin
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    if (stat.slot_last) begin
                        state_reg <= ST_FILL;
                        ready_reg <= 1'b1;
                    end else begin
                        state_reg <= ST_READ;
                    end
                end
                default: begin
                    state_reg <= ST_FILL;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

    assign cmd.accept_en = ready_reg;
    assign cmd.rd_issue  = (state_reg == ST_READ) && !stat.out_busy;
    assign cmd.load      = (state_reg == ST_LOAD);

endmodule

@@ hw/rtl/vobc_dp.sv @@
// Datapath for the block chopper: config registers, fill counter, sample store,
// slot addressing and the output register. Depends on vobc_pkg and vobc_ram.
module vobc_dp #(
    parameter int MAX_READ     = 256,
    parameter int MAX_WRITE    = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    input  logic [vobc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [vobc_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  s_valid,
    input  logic signed [SAMPLE_WIDTH-1:0]        s_sample,
    input  logic signed [vobc_pkg::OFS_W-1:0]     s_offset,
    input  logic                                  m_ready,
    output logic                                  m_valid,
    output logic signed [vobc_pkg::OUT_W-1:0]     m_out_sample,
    output logic                                  m_last,
    input  vobc_pkg::vobc_cmd_t                   cmd,
    output vobc_pkg::vobc_stat_t                  stat
);

    localparam int ADDR_W = (MAX_READ > 1) ? $clog2(MAX_READ) : 1;
    localparam int FC_W   = $clog2(MAX_READ + 1);
    localparam int KI_W   = (MAX_WRITE > 1) ? $clog2(MAX_WRITE) : 1;
    localparam int WC_W   = $clog2(MAX_WRITE + 1);

    logic [vobc_pkg::RC_REG_W-1:0] read_count_reg;
    logic [vobc_pkg::WC_REG_W-1:0] write_count_reg;
    logic [FC_W-1:0]               fill_count_reg;
    logic [FC_W-1:0]               rc_lat_reg;
    logic [WC_W-1:0]               wc_lat_reg;
    logic [vobc_pkg::PAD_W-1:0]    pad_reg;
    logic [vobc_pkg::IDX_W-1:0]    skip_reg;
    logic [KI_W-1:0]               slot_reg;
    logic                          hit_reg;
    logic                          out_valid_reg;
    logic [vobc_pkg::OUT_W-1:0]    out_sample_reg;
    logic                          out_last_reg;

    logic [31:0]                   rc_wide;
    logic [31:0]                   wc_wide;
    logic [FC_W-1:0]               rc_eff;
    logic [WC_W-1:0]               wc_eff;
    logic                          accept;
    logic [vobc_pkg::IDX_W-1:0]    src_idx;
    logic                          slot_hit;
    logic [SAMPLE_WIDTH-1:0]       rd_data;
    logic [SAMPLE_WIDTH+vobc_pkg::OUT_W-1:0] rd_ext;

    // Clamp the registers into their usable ranges.
    always_comb begin
        priority if (read_count_reg == '0) begin
            rc_wide = 32'd1;
        end else if (32'(read_count_reg) > 32'(MAX_READ)) begin
            rc_wide = 32'(MAX_READ);
        end else begin
            rc_wide = 32'(read_count_reg);
        end
        priority if (write_count_reg == '0) begin
            wc_wide = 32'd1;
        end else if (32'(write_count_reg) > 32'(MAX_WRITE)) begin
            wc_wide = 32'(MAX_WRITE);
        end else begin
            wc_wide = 32'(write_count_reg);
        end
    end
    assign rc_eff = rc_wide[FC_W-1:0];
    assign wc_eff = wc_wide[WC_W-1:0];

    assign accept          = s_valid && cmd.accept_en;
    assign stat.block_done = accept && ((32'(fill_count_reg) + 32'd1) >= 32'(rc_eff));
    assign stat.out_busy   = out_valid_reg && !m_ready;
    assign stat.slot_last  = (32'(slot_reg) + 32'd1) == 32'(wc_lat_reg);

    // Configuration: index beyond the register list is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            read_count_reg  <= vobc_pkg::RC_RESET;
            write_count_reg <= vobc_pkg::WC_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == vobc_pkg::REG_READ_COUNT) begin
                read_count_reg <= cfg_data[vobc_pkg::RC_REG_W-1:0];
            end else if (cfg_index == vobc_pkg::REG_WRITE_COUNT) begin
                write_count_reg <= cfg_data[vobc_pkg::WC_REG_W-1:0];
            end
        end
    end

    // Fill counter and slot counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_count_reg <= '0;
            slot_reg       <= '0;
        end else begin
            if (stat.block_done) begin
                fill_count_reg <= '0;
                slot_reg       <= '0;
            end else if (accept) begin
                fill_count_reg <= fill_count_reg + 1'b1;
            end
            if (cmd.load) begin
                slot_reg <= stat.slot_last ? '0 : slot_reg + 1'b1;
            end
        end
    end

    // Latch the block's shift and lengths on the completing transaction.
    always_ff @(posedge aclk) begin
        if (stat.block_done) begin
            rc_lat_reg <= rc_eff;
            wc_lat_reg <= wc_eff;
            if (s_offset[vobc_pkg::OFS_W-1]) begin
                pad_reg  <= '0;
                skip_reg <= vobc_pkg::IDX_W'(17'h10000 - {1'b0, s_offset});
            end else begin
                pad_reg  <= s_offset[vobc_pkg::PAD_W-1:0];
                skip_reg <= '0;
            end
        end
    end

    // Source index for the current slot; out-of-block slots give zero.
    assign src_idx  = vobc_pkg::IDX_W'(slot_reg) - vobc_pkg::IDX_W'(pad_reg) + skip_reg;
    assign slot_hit = (32'(slot_reg) >= 32'(pad_reg)) && (32'(src_idx) < 32'(rc_lat_reg));

    always_ff @(posedge aclk) begin
        if (cmd.rd_issue) begin
            hit_reg <= slot_hit;
        end
    end

    vobc_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (MAX_READ)
    ) u_store (
        .aclk  (aclk),
        .we    (accept),
        .waddr (fill_count_reg[ADDR_W-1:0]),
        .wdata (s_sample),
        .re    (cmd.rd_issue),
        .raddr (src_idx[ADDR_W-1:0]),
        .rdata (rd_data)
    );

    // Zero-extend or truncate the stored sample to the output field.
    assign rd_ext = {{vobc_pkg::OUT_W{1'b0}}, rd_data};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_sample_reg <= hit_reg ? rd_ext[vobc_pkg::OUT_W-1:0] : '0;
            out_last_reg   <= stat.slot_last;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_out_sample = out_sample_reg;
    assign m_last       = out_last_reg;

`ifndef SYNTH
    a_load_into_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> !out_valid_reg)
        else $error("output register overwritten");
    a_read_then_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_issue |=> cmd.load)
        else $error("store read not followed by load");
    a_fill_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(fill_count_reg) < 32'(MAX_READ))
        else $error("fill count beyond store depth");
    a_slot_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load && stat.slot_last) |=> (slot_reg == '0))
        else $error("slot counter did not wrap after last result");
`endif

endmodule

@@ hw/rtl/variable_offset_block_chopper_unit.sv @@
// Top level of the variable-offset block chopper.
// Depends on vobc_pkg, vobc_ctrl, vobc_dp (and vobc_ram through vobc_dp).
//
//  channel  | ports                                    | direction
//  ---------+------------------------------------------+----------
//  config   | cfg_valid cfg_ready cfg_index cfg_data   | in
//  input    | s_valid s_ready s_sample s_offset        | in
//  result   | m_valid m_ready m_out_sample m_last      | out
//
// Flow: a mid-block transaction is taken whenever the input is open. The completing
// transaction closes the input; each result then takes a store read, then an
// output-register load, a sequence set by the registered read of the sample store;
// the read waits while the output register is full and m_ready is low.
// Input reopens once the last result sits in the output register.
// Reset: synchronous, active low; counters cleared, read_count 128,
// write_count 64; the sample store is not cleared. cfg_ready is always high.
module variable_offset_block_chopper_unit #(
    parameter int MAX_READ     = 256,
    parameter int MAX_WRITE    = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [vobc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vobc_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]      s_sample,
    input  logic signed [vobc_pkg::OFS_W-1:0]   s_offset,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [vobc_pkg::OUT_W-1:0]   m_out_sample,
    output logic                                m_last
);

    vobc_pkg::vobc_cmd_t  cmd;
    vobc_pkg::vobc_stat_t stat;

    // Registers take a write in any cycle.
    assign cfg_ready = 1'b1;
    // Hold the input channel closed while a block drains.
    assign s_ready   = cmd.accept_en;

    vobc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .cmd     (cmd)
    );

    vobc_dp #(
        .MAX_READ     (MAX_READ),
        .MAX_WRITE    (MAX_WRITE),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_sample     (s_sample),
        .s_offset     (s_offset),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_out_sample (m_out_sample),
        .m_last       (m_last),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for variable_offset_block_chopper_unit.
// Depends on vobc_pkg and the chopper RTL; a tracker class predicts every
// result from the accepted samples and the register writes, and checks them.
module tb;

    localparam int          MAX_READ      = 256;
    localparam int          MAX_WRITE     = 64;
    localparam int          SAMPLE_WIDTH  = 16;
    localparam int unsigned RANDOM_ITEMS  = 340;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT   = 3_000_000;

    // One result as the block should present it.
    typedef struct packed {
        logic [15:0] smp;
        logic        last;
    } chop_result_t;

    // Tracks the block's registers and sample store, queues the results
    // each completed block must produce, and checks them in order.
    class chop_tracker;
        logic [15:0]  sample_mem [MAX_READ];
        int unsigned  fill;
        logic [8:0]   read_len;
        logic [6:0]   write_len;
        chop_result_t expected_out [$];
        int unsigned  mismatches;
        int unsigned  results_seen;
        int unsigned  samples_seen;
        int unsigned  reg_writes;

        function new();
            fill         = 0;
            read_len     = vobc_pkg::RC_RESET;
            write_len    = vobc_pkg::WC_RESET;
            mismatches   = 0;
            results_seen = 0;
            samples_seen = 0;
            reg_writes   = 0;
        endfunction

        // Zero acts as one, anything past the buffer size acts as the size.
        static function int unsigned clamp_len(int unsigned v, int unsigned hi);
            if (v == 0) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function int unsigned pending();
            return expected_out.size();
        endfunction

        function void set_reg(logic [vobc_pkg::CFG_IDX_W-1:0] idx,
                              logic [vobc_pkg::CFG_DATA_W-1:0] data);
            reg_writes++;
            if (idx == vobc_pkg::REG_READ_COUNT)
                read_len = data;
            else if (idx == vobc_pkg::REG_WRITE_COUNT)
                write_len = data[6:0];
        endfunction

        function void take_sample(logic signed [15:0] smp, logic signed [15:0] ofs);
            int unsigned  rc;
            int unsigned  wc;
            int unsigned  pad;
            int unsigned  skip;
            int unsigned  src;
            chop_result_t item;
            samples_seen++;
            rc = clamp_len(read_len, MAX_READ);
            if (fill < MAX_READ)
                sample_mem[fill] = smp;
            fill++;
            if (fill < rc)
                return;
            fill = 0;
            wc = clamp_len(write_len, MAX_WRITE);
            if (ofs < 0) begin
                pad  = 0;
                skip = -int'(ofs);
            end else begin
                pad  = int'(ofs);
                skip = 0;
            end
            for (int unsigned k = 0; k < wc; k++) begin
                item.smp = '0;
                if (k >= pad) begin
                    src = k - pad + skip;
                    if (src < rc)
                        item.smp = sample_mem[src];
                end
                item.last = (k + 1 == wc);
                expected_out.push_back(item);
            end
        endfunction

        function void note_fail(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%s", msg);
        endfunction

        function void check_result(logic [15:0] smp, logic last);
            chop_result_t exp_item;
            if (expected_out.size() == 0) begin
                note_fail($sformatf("unexpected result: sample %0d last %0b",
                                    $signed(smp), last));
                return;
            end
            exp_item = expected_out.pop_front();
            if (exp_item.smp !== smp || exp_item.last !== last)
                note_fail($sformatf("result %0d: expected sample %0d last %0b, got sample %0d last %0b",
                                    results_seen, $signed(exp_item.smp), exp_item.last,
                                    $signed(smp), last));
            results_seen++;
        endfunction
    endclass

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [vobc_pkg::CFG_IDX_W-1:0]    cfg_index = vobc_pkg::REG_READ_COUNT;
    logic [vobc_pkg::CFG_DATA_W-1:0]   cfg_data  = '0;

    logic                              s_valid  = 1'b0;
    logic                              s_ready;
    logic signed [SAMPLE_WIDTH-1:0]    s_sample = '0;
    logic signed [vobc_pkg::OFS_W-1:0] s_offset = '0;

    logic                              m_valid;
    logic                              m_ready = 1'b0;
    logic signed [vobc_pkg::OUT_W-1:0] m_out_sample;
    logic                              m_last;

    // Phase-wide switches that turn off the random gaps on either side.
    logic tx_calm = 1'b0;
    logic rx_calm = 1'b0;

    int unsigned cycle_count = 0;
    chop_tracker tracker = new();

    variable_offset_block_chopper_unit #(
        .MAX_READ    (MAX_READ),
        .MAX_WRITE   (MAX_WRITE),
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .s_offset    (s_offset),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_sample(m_out_sample),
        .m_last      (m_last)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Abort a run that hangs; the limit is several times the slowest legal run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, tracker.pending());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Observe every handshake at the edge that completes it. Results are
    // checked before the new sample is noted; a completing sample only
    // queues results behind whatever is still pending.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                tracker.set_reg(cfg_index, cfg_data);
            if (m_valid && m_ready)
                tracker.check_result(m_out_sample, m_last);
            if (s_valid && s_ready)
                tracker.take_sample(s_sample, s_offset);
        end
    end

    // Result side: draw a stall for every result, then hold ready until the
    // transaction goes through.
    initial begin : result_sink
        int unsigned stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = rx_calm ? 0 : $urandom_range(15);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // Offer one sample after a random gap and hold it until accepted.
    // Valid is left high so a back-to-back sample keeps it up.
    task automatic push_sample(input logic signed [15:0] smp,
                               input logic signed [15:0] ofs);
        int unsigned gap;
        gap = tx_calm ? 0 : $urandom_range(15);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= smp;
        s_offset <= ofs;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid, wait for every queued result, then let the block settle.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (tracker.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write both length registers while the block is idle.
    task automatic write_counts(input logic [8:0] rc_data, input logic [8:0] wc_data);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= vobc_pkg::REG_READ_COUNT;
        cfg_data  <= rc_data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= vobc_pkg::REG_WRITE_COUNT;
        cfg_data  <= wc_data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] pick_sample();
        int unsigned roll;
        roll = $urandom_range(7);
        if (roll == 0) return 16'sh7FFF;
        if (roll == 1) return 16'sh8000;
        return 16'($urandom());
    endfunction

    // Mostly shifts around the interesting range (past both block ends by
    // one), some full-range values and the two extremes.
    function automatic logic signed [15:0] pick_offset(int unsigned rc, int unsigned wc);
        int unsigned roll;
        int          span;
        roll = $urandom_range(15);
        if (roll == 0) return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        if (roll < 3) return 16'($urandom());
        span = $urandom_range(rc + wc + 2);
        return 16'(span - int'(rc) - 1);
    endfunction

    initial begin : stimulus
        int unsigned i;
        int unsigned n;
        int unsigned kind;
        int unsigned phase;
        int unsigned blocks;
        int unsigned eff_rc;
        int unsigned eff_wc;
        int unsigned random_sent;
        logic [8:0]  rc_data;
        logic [8:0]  wc_data;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset lengths: one full block of 128 samples gives 64 results.
        for (i = 0; i < 128; i++)
            push_sample(pick_sample(), pick_offset(128, 64));

        // Straight copy with the sample extremes, then a pad and a skip.
        write_counts(9'd4, 9'd8);
        push_sample(16'sh7FFF, 16'($urandom()));
        push_sample(16'sh8000, 16'($urandom()));
        push_sample(16'sh0000, 16'($urandom()));
        push_sample(-16'sd1, 16'sd0);
        push_sample(16'sd1, 16'($urandom()));
        push_sample(16'sd2, 16'($urandom()));
        push_sample(16'sd3, 16'($urandom()));
        push_sample(16'sd4, 16'sd3);
        push_sample(16'sh5A5A, 16'($urandom()));
        push_sample(16'shA5A5, 16'($urandom()));
        push_sample(16'sh0FF0, 16'($urandom()));
        push_sample(16'shF00F, -16'sd2);

        // One-sample blocks: shifts at and past both block lengths.
        write_counts(9'd1, 9'd8);
        push_sample(16'sh1234, 16'sd8);
        push_sample(16'sh4321, 16'sd7);
        push_sample(16'sh5555, -16'sd1);
        push_sample(16'shAAAA, 16'sd0);
        push_sample(16'sh7FFF, 16'sh7FFF);
        push_sample(16'sh8000, 16'sh8000);

        // Zero registers act as one.
        write_counts(9'd0, 9'd0);
        push_sample(16'sh3C3C, 16'sd0);
        push_sample(16'shC3C3, -16'sd1);

        // Write length above the limit (upper data bits dropped, then capped).
        write_counts(9'd0, 9'h1C5);
        push_sample(16'sh0F0F, 16'sd60);

        // Shorten the block while four samples already sit in the store.
        write_counts(9'd6, 9'd6);
        for (i = 0; i < 4; i++)
            push_sample(pick_sample(), 16'($urandom()));
        write_counts(9'd2, 9'd6);
        push_sample(16'sh6666, -16'sd1);

        // Random phases: mostly short blocks, each phase at new lengths.
        phase       = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            kind = $urandom_range(15);
            if (phase == 3)
                kind = 0;
            else if (kind == 0)
                kind = 4;
            case (kind)
                0: begin
                    // longest blocks, once
                    rc_data = $urandom_range(1) ? 9'd256 : 9'($urandom_range(257, 511));
                    wc_data = {2'($urandom()), 7'($urandom_range(64, 127))};
                end
                1: begin
                    rc_data = 9'd0;
                    wc_data = 9'($urandom());
                end
                2: begin
                    rc_data = 9'($urandom_range(1, 4));
                    wc_data = {2'($urandom()), 7'd0};
                end
                default: begin
                    rc_data = 9'($urandom_range(1, 12));
                    wc_data = {2'($urandom()), 7'($urandom_range(1, 20))};
                end
            endcase
            eff_rc = chop_tracker::clamp_len(rc_data, MAX_READ);
            eff_wc = chop_tracker::clamp_len(wc_data[6:0], MAX_WRITE);
            blocks = (eff_rc > 32) ? 1 : $urandom_range(1, 4);
            n      = blocks * eff_rc;
            // leave a partial block behind now and then
            if (eff_rc > 1 && eff_rc <= 32 && $urandom_range(3) == 0)
                n += $urandom_range(eff_rc - 1);
            tx_calm = ($urandom_range(3) == 0);
            rx_calm = ($urandom_range(3) == 0);
            write_counts(rc_data, wc_data);
            for (i = 0; i < n; i++)
                push_sample(pick_sample(), pick_offset(eff_rc, eff_wc));
            random_sent += n;
            phase++;
        end

        wait_drained();
        $display("run covered %0d input transactions (%0d random, %0d phases), %0d register writes",
                 tracker.samples_seen, random_sent, phase, tracker.reg_writes);
        $display("checked %0d results, %0d mismatches", tracker.results_seen,
                 tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/vobc_pkg.sv
hw/rtl/vobc_ram.sv
hw/rtl/vobc_ctrl.sv
hw/rtl/vobc_dp.sv
hw/rtl/variable_offset_block_chopper_unit.sv
tb/tb.sv
